>>> src/ccss_pkg.sv
package ccss_pkg;

	localparam int CCSS_WORD_BITS   = 64;
	localparam int CCSS_WSEL_W      = 4;
	localparam int CCSS_BIT_W       = $clog2(CCSS_WORD_BITS);
	localparam int CCSS_ADDR_COLS   = CCSS_WORD_BITS * (2 ** CCSS_WSEL_W);
	localparam int CCSS_COL_W       = CCSS_BIT_W + CCSS_WSEL_W;
	localparam int CCSS_CC_W        = 11;
	localparam int CCSS_NWORDS_W    = CCSS_CC_W - CCSS_BIT_W + 1;
	localparam int CCSS_DELTA_W     = 29;
	localparam int CCSS_SCORE_W     = 35;
	localparam int CCSS_WSCORE_W    = 34;
	localparam int CCSS_COLUMNS_DEF = 1024;
	localparam int CCSS_MAXCNT_DEF  = 255;

	localparam logic [1:0] ACT_CLEAR = 2'd0;
	localparam logic [1:0] ACT_EVAL  = 2'd1;
	localparam logic [1:0] ACT_APPLY = 2'd2;

	typedef struct packed {
		logic vld;
		logic add;
	} col_op_t;

endpackage

>>> src/ccss_count_ram.sv
module ccss_count_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> src/ccss_delta_unit.sv
module ccss_delta_unit
	import ccss_pkg::*;
#(
	parameter int MAX_COUNT = CCSS_MAXCNT_DEF,
	parameter int CW        = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  col_op_t                 op,
	input  logic                    apply,
	input  logic [CW-1:0]           rd_data,
	output logic                    wr_en,
	output logic [CW-1:0]           wr_data,
	output logic                    contrib_vld,
	output logic [CCSS_SCORE_W-1:0] contrib
);

	localparam int XW = CW + 2;
	localparam int PW = CW + XW;

	col_op_t       op_s1;
	logic          sat;
	logic [CW-1:0] m_cnt;
	logic [CW-1:0] k_cnt;
	logic          vld_s2;
	logic          add_s2;
	logic [CW-1:0] k_s2;
	logic [XW-1:0] x_s2;
	logic          vld_s3;
	logic          add_s3;
	logic [PW-1:0] prod_s3;

	// count moving from k to k+1 changes the score by k*(3k-1)
	always_comb begin
		sat   = op_s1.add ? (rd_data == CW'(MAX_COUNT)) : (rd_data == '0);
		m_cnt = op_s1.add ? rd_data + CW'(1) : rd_data - CW'(1);
		k_cnt = op_s1.add ? rd_data : m_cnt;
	end

	assign wr_en   = op_s1.vld & apply & ~sat;
	assign wr_data = m_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1  <= '0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			op_s1  <= op;
			vld_s2 <= op_s1.vld & ~sat;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		add_s2  <= op_s1.add;
		k_s2    <= k_cnt;
		x_s2    <= ({2'b00, k_cnt} << 1) + {2'b00, k_cnt} - XW'(1);
		add_s3  <= add_s2;
		prod_s3 <= PW'(k_s2) * PW'(x_s2);
	end

	assign contrib_vld = vld_s3;
	assign contrib     = add_s3 ? CCSS_SCORE_W'(prod_s3) : -CCSS_SCORE_W'(prod_s3);

endmodule

>>> src/column_count_swap_scorer_top.sv
// channel | signals                                      | direction
// config  | cfg_we, cfg_wdata                            | in, written when cfg_we is high
// item    | start, busy, action, word_sel, exit_word,    | in, taken when start & ~busy
//         | in_word                                      |
// result  | done, delta_so_far, window_score, row_done   | out, one cycle, no back-pressure
//
// evaluate or apply of a word in the row: busy while the count of each column of the word is read
// (and, on apply, written back where it changes), the multiplier pipeline drains and the result is
// formed; result in the cycle after. clear: a clearing pass over COLUMNS (at most 1024) memory
// entries, then the result. a word past the row or an unused action gives its result next cycle.
// after reset the block is busy for the same clearing pass, with no result.
// results cannot be stalled; each is shown for one cycle only.
module column_count_swap_scorer_top
	import ccss_pkg::*;
#(
	parameter int COLUMNS   = CCSS_COLUMNS_DEF,
	parameter int MAX_COUNT = CCSS_MAXCNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [CCSS_CC_W-1:0]            cfg_wdata,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      action,
	input  logic [CCSS_WSEL_W-1:0]          word_sel,
	input  logic [CCSS_WORD_BITS-1:0]       exit_word,
	input  logic [CCSS_WORD_BITS-1:0]       in_word,
	output logic                            done,
	output logic signed [CCSS_DELTA_W-1:0]  delta_so_far,
	output logic [CCSS_WSCORE_W-1:0]        window_score,
	output logic                            row_done
);

	localparam int MEM_DEPTH = (COLUMNS < CCSS_ADDR_COLS) ? COLUMNS : CCSS_ADDR_COLS;
	localparam int AW        = $clog2(MEM_DEPTH);
	localparam int CW        = $clog2(MAX_COUNT + 1);
	localparam int COL_LIM   = (COLUMNS < (2 ** CCSS_CC_W) - 1) ? COLUMNS
	                                                            : (2 ** CCSS_CC_W) - 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} state_t;

	state_t                    state_q;
	logic [CCSS_CC_W-1:0]      col_cnt_q;
	logic [AW-1:0]             clr_addr_q;
	logic                      clr_report_q;
	logic [CCSS_BIT_W-1:0]     bit_q;
	logic [1:0]                drain_q;
	logic                      apply_q;
	logic                      last_q;
	logic [CCSS_WSEL_W-1:0]    widx_q;
	logic [CCSS_WORD_BITS-1:0] chg_q;
	logic [CCSS_WORD_BITS-1:0] add_q;
	logic [CCSS_DELTA_W-1:0]   delta_acc_q;
	logic [CCSS_SCORE_W-1:0]   score_q;
	logic                      done_q;
	logic [CCSS_DELTA_W-1:0]   delta_out_q;
	logic [CCSS_WSCORE_W-1:0]  score_out_q;
	logic                      row_done_q;
	logic [AW-1:0]             addr_s1;

	logic [CCSS_CC_W-1:0]      cols;
	logic [CCSS_NWORDS_W-1:0]  nwords;
	logic [CCSS_NWORDS_W-1:0]  widx_ext;
	logic                      in_row;
	logic                      is_last;
	logic [CCSS_BIT_W-1:0]     rem;
	logic [CCSS_WORD_BITS-1:0] tail;
	logic [CCSS_WORD_BITS-1:0] ow_m;
	logic [CCSS_WORD_BITS-1:0] iw_m;
	logic                      accept;
	logic                      rpt_now;
	logic [CCSS_COL_W-1:0]     col;
	logic [AW-1:0]             rd_addr;
	col_op_t                   op;
	logic [CW-1:0]             rd_data;
	logic                      du_wr_en;
	logic [CW-1:0]             du_wr_data;
	logic                      mem_we;
	logic [AW-1:0]             mem_waddr;
	logic [CW-1:0]             mem_wdata;
	logic                      contrib_vld;
	logic [CCSS_SCORE_W-1:0]   contrib;

	// clamp the column count, then derive words per row and the last-word mask
	always_comb begin
		if (col_cnt_q == '0) begin
			cols = CCSS_CC_W'(1);
		end else if (col_cnt_q > CCSS_CC_W'(COL_LIM)) begin
			cols = CCSS_CC_W'(COL_LIM);
		end else begin
			cols = col_cnt_q;
		end
		nwords   = CCSS_NWORDS_W'(cols[CCSS_CC_W-1:CCSS_BIT_W])
		         + CCSS_NWORDS_W'(|cols[CCSS_BIT_W-1:0]);
		widx_ext = CCSS_NWORDS_W'(word_sel);
		in_row   = widx_ext < nwords;
		is_last  = (widx_ext + CCSS_NWORDS_W'(1)) == nwords;
		rem      = cols[CCSS_BIT_W-1:0];
		tail     = (rem == '0) ? '1 : ((CCSS_WORD_BITS'(1) << rem) - CCSS_WORD_BITS'(1));
		ow_m     = is_last ? (exit_word & tail) : exit_word;
		iw_m     = is_last ? (in_word & tail) : in_word;
	end

	assign busy   = (state_q != S_IDLE);
	assign accept = start & ~busy;

	// a result goes out at this edge
	assign rpt_now = (state_q == S_FINISH)
	               | ((state_q == S_CLEAR) & clr_report_q
	                  & (clr_addr_q == AW'(MEM_DEPTH - 1)))
	               | (accept & (action != ACT_CLEAR)
	                  & ~((action == ACT_EVAL || action == ACT_APPLY) && in_row));

	assign col     = {widx_q, bit_q};
	assign rd_addr = col[AW-1:0];

	always_comb begin
		op.vld = (state_q == S_SCAN) & chg_q[bit_q];
		op.add = add_q[bit_q];
	end

	always_comb begin
		if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_addr_q;
			mem_wdata = '0;
		end else begin
			mem_we    = du_wr_en;
			mem_waddr = addr_s1;
			mem_wdata = du_wr_data;
		end
	end

	ccss_count_ram #(
		.DEPTH (MEM_DEPTH),
		.AW    (AW),
		.DW    (CW)
	) u_ram (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	ccss_delta_unit #(
		.MAX_COUNT (MAX_COUNT),
		.CW        (CW)
	) u_delta (
		.clk         (clk),
		.arst_n      (arst_n),
		.op          (op),
		.apply       (apply_q),
		.rd_data     (rd_data),
		.wr_en       (du_wr_en),
		.wr_data     (du_wr_data),
		.contrib_vld (contrib_vld),
		.contrib     (contrib)
	);

	always_ff @(posedge clk) begin
		addr_s1 <= rd_addr;
		if (accept) begin
			widx_q <= word_sel;
			chg_q  <= ow_m ^ iw_m;
			add_q  <= iw_m & ~ow_m;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			col_cnt_q    <= CCSS_CC_W'(CCSS_ADDR_COLS);
			clr_addr_q   <= '0;
			clr_report_q <= 1'b0;
			bit_q        <= '0;
			drain_q      <= '0;
			apply_q      <= 1'b0;
			last_q       <= 1'b0;
			delta_acc_q  <= '0;
			score_q      <= '0;
			done_q       <= 1'b0;
			delta_out_q  <= '0;
			score_out_q  <= '0;
			row_done_q   <= 1'b0;
		end else begin
			done_q <= rpt_now;
			if (cfg_we) begin
				col_cnt_q <= cfg_wdata;
			end
			if (contrib_vld) begin
				delta_acc_q <= delta_acc_q + contrib[CCSS_DELTA_W-1:0];
				if (apply_q) begin
					score_q <= score_q + contrib;
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (action == ACT_CLEAR) begin
							delta_acc_q  <= '0;
							score_q      <= '0;
							clr_addr_q   <= '0;
							clr_report_q <= 1'b1;
							state_q      <= S_CLEAR;
						end else if ((action == ACT_EVAL || action == ACT_APPLY) && in_row) begin
							apply_q <= (action == ACT_APPLY);
							last_q  <= is_last;
							bit_q   <= '0;
							state_q <= S_SCAN;
						end else begin
							// nothing to do: report the current totals
							delta_out_q <= delta_acc_q;
							score_out_q <= score_q[CCSS_WSCORE_W-1:0];
							row_done_q  <= 1'b0;
						end
					end
				end
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + AW'(1);
					if (clr_addr_q == AW'(MEM_DEPTH - 1)) begin
						state_q      <= S_IDLE;
						clr_report_q <= 1'b0;
						if (clr_report_q) begin
							delta_out_q <= '0;
							score_out_q <= '0;
							row_done_q  <= 1'b0;
						end
					end
				end
				S_SCAN: begin
					bit_q <= bit_q + CCSS_BIT_W'(1);
					if (bit_q == '1) begin
						drain_q <= '0;
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					drain_q <= drain_q + 2'd1;
					if (drain_q == 2'd2) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					delta_out_q <= delta_acc_q;
					score_out_q <= score_q[CCSS_WSCORE_W-1:0];
					row_done_q  <= last_q;
					if (last_q) begin
						delta_acc_q <= '0;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done         = done_q;
	assign delta_so_far = delta_out_q;
	assign window_score = score_out_q;
	assign row_done     = row_done_q;

endmodule
